@@ hdl/nls_pkg.sv @@
// Shared types, scan phase codes and character constants for the numeric literal scanner.
`default_nettype none

package nls_pkg;

   // Input word: one source byte and its token start flag.
   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
   } req_word_type;

   // Result word: one recognized literal.
   typedef struct packed {
      logic [1:0] num_base;
      logic       is_float;
      logic       malformed;
      logic [7:0] token_length;
   } rsp_word_type;

   // Character class flags decoded from one byte.
   typedef struct packed {
      logic is_digit;
      logic is_dot;
      logic is_zero;
      logic is_x;
      logic is_b;
      logic is_hex;
      logic is_bin;
      logic compatible;
   } char_class_type;

   // One scan step as seen by the output stage.
   typedef struct packed {
      logic         done;
      rsp_word_type rsp;
   } step_out_type;

   // Numeric base codes.
   localparam logic [1:0] BaseDec = 2'd0;
   localparam logic [1:0] BaseHex = 2'd1;
   localparam logic [1:0] BaseBin = 2'd2;

   // Scan phase codes.
   localparam logic [3:0] PhIdle     = 4'd0;
   localparam logic [3:0] PhZero     = 4'd1;
   localparam logic [3:0] PhDecInt   = 4'd2;
   localparam logic [3:0] PhDecFrac  = 4'd3;
   localparam logic [3:0] PhLeadDot  = 4'd4;
   localparam logic [3:0] PhLeadFrac = 4'd5;
   localparam logic [3:0] PhHexFirst = 4'd6;
   localparam logic [3:0] PhHexDigs  = 4'd7;
   localparam logic [3:0] PhBinFirst = 4'd8;
   localparam logic [3:0] PhBinDigs  = 4'd9;

   // Character codes.
   localparam logic [7:0] ChNul    = 8'h00;
   localparam logic [7:0] ChTab    = 8'h09;
   localparam logic [7:0] ChLf     = 8'h0A;
   localparam logic [7:0] ChCr     = 8'h0D;
   localparam logic [7:0] ChSpace  = 8'h20;
   localparam logic [7:0] ChBang   = 8'h21;
   localparam logic [7:0] ChTilde  = 8'h7E;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChZero   = 8'h30;
   localparam logic [7:0] ChOne    = 8'h31;
   localparam logic [7:0] ChNine   = 8'h39;
   localparam logic [7:0] ChUpperA = 8'h41;
   localparam logic [7:0] ChUpperF = 8'h46;
   localparam logic [7:0] ChUpperZ = 8'h5A;
   localparam logic [7:0] ChUnder  = 8'h5F;
   localparam logic [7:0] ChLowerA = 8'h61;
   localparam logic [7:0] ChLowerB = 8'h62;
   localparam logic [7:0] ChLowerF = 8'h66;
   localparam logic [7:0] ChLowerX = 8'h78;
   localparam logic [7:0] ChLowerZ = 8'h7A;

endpackage

`default_nettype wire

@@ hdl/nls_char_class.sv @@
// Byte class decoder: digit, base digit and follower checks for one source byte.
`default_nettype none

module nls_char_class (
   input  wire logic [7:0]             ch,
   output nls_pkg::char_class_type     cls
);

   logic is_letter;
   logic is_blank;
   logic is_print;

   // Letters and underscore count as identifier characters.
   assign is_letter = (ch >= nls_pkg::ChUpperA && ch <= nls_pkg::ChUpperZ) ||
                      (ch >= nls_pkg::ChLowerA && ch <= nls_pkg::ChLowerZ) ||
                      (ch == nls_pkg::ChUnder);

   // Whitespace, newline and end of file end a literal cleanly.
   assign is_blank = (ch == nls_pkg::ChSpace) || (ch == nls_pkg::ChTab) ||
                     (ch == nls_pkg::ChCr) || (ch == nls_pkg::ChLf) ||
                     (ch == nls_pkg::ChNul);

   assign is_print = (ch >= nls_pkg::ChBang) && (ch <= nls_pkg::ChTilde);

   // Class flags for the scan step.
   always_comb begin
      cls.is_digit   = (ch >= nls_pkg::ChZero) && (ch <= nls_pkg::ChNine);
      cls.is_dot     = (ch == nls_pkg::ChDot);
      cls.is_zero    = (ch == nls_pkg::ChZero);
      cls.is_x       = (ch == nls_pkg::ChLowerX);
      cls.is_b       = (ch == nls_pkg::ChLowerB);
      cls.is_hex     = cls.is_digit ||
                       (ch >= nls_pkg::ChLowerA && ch <= nls_pkg::ChLowerF) ||
                       (ch >= nls_pkg::ChUpperA && ch <= nls_pkg::ChUpperF);
      cls.is_bin     = (ch == nls_pkg::ChZero) || (ch == nls_pkg::ChOne);
      cls.compatible = is_blank || (is_print && !cls.is_digit && !is_letter);
   end

endmodule

`default_nettype wire

@@ hdl/nls_scan_core.sv @@
// Scan state registers and the one-byte phase update of the literal recognizer.
`default_nettype none

module nls_scan_core #(
   parameter int unsigned MAX_LEN = 255
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step_en,
   input  wire nls_pkg::req_word_type word,
   output nls_pkg::step_out_type      step_out
);

   localparam logic [7:0] LenLimit = (MAX_LEN < 255) ? 8'(MAX_LEN) : 8'd255;

   nls_pkg::char_class_type cls;

   logic [3:0] phase_ff;
   logic [3:0] phase_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;

   logic [7:0] count_take;
   logic       dec_path;
   logic [3:0] phase_mid;
   logic [7:0] count_mid;

   nls_char_class u_class (
      .ch  (word.ch),
      .cls (cls)
   );

   // Count with saturation at the length limit.
   assign count_take = (count_ff < LenLimit) ? count_ff + 8'd1 : count_ff;

   // A lone leading zero continues as a decimal integer unless x or b follows.
   assign dec_path = (phase_ff == nls_pkg::PhDecInt) ||
                     ((phase_ff == nls_pkg::PhZero) && !cls.is_x && !cls.is_b);

   // Phase update for the current byte, then the optional token start.
   always_comb begin
      step_out.done               = 1'b0;
      step_out.rsp.num_base       = nls_pkg::BaseDec;
      step_out.rsp.is_float       = 1'b0;
      step_out.rsp.malformed      = 1'b0;
      step_out.rsp.token_length   = count_ff;
      phase_mid                   = phase_ff;
      count_mid                   = count_ff;

      unique case (phase_ff) inside
         nls_pkg::PhZero, nls_pkg::PhDecInt: begin
            if (!dec_path && cls.is_x) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhHexFirst;
            end else if (!dec_path) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhBinFirst;
            end else if (cls.is_digit) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhDecInt;
            end else if (cls.is_dot) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhDecFrac;
            end else begin
               step_out.done          = 1'b1;
               step_out.rsp.malformed = !cls.compatible;
            end
         end
         nls_pkg::PhDecFrac: begin
            if (cls.is_digit) begin
               count_mid = count_take;
            end else begin
               step_out.done          = 1'b1;
               step_out.rsp.is_float  = 1'b1;
               step_out.rsp.malformed = !cls.compatible;
            end
         end
         nls_pkg::PhLeadDot: begin
            if (cls.is_digit) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhLeadFrac;
            end else begin
               step_out.done          = 1'b1;
               step_out.rsp.is_float  = 1'b1;
               step_out.rsp.malformed = 1'b1;
            end
         end
         nls_pkg::PhLeadFrac: begin
            if (cls.is_digit) begin
               count_mid = count_take;
            end else begin
               step_out.done         = 1'b1;
               step_out.rsp.is_float = 1'b1;
            end
         end
         nls_pkg::PhHexFirst, nls_pkg::PhHexDigs: begin
            if (cls.is_hex) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhHexDigs;
            end else begin
               step_out.done          = 1'b1;
               step_out.rsp.num_base  = nls_pkg::BaseHex;
               step_out.rsp.malformed = (phase_ff == nls_pkg::PhHexFirst) ||
                                        !cls.compatible;
            end
         end
         nls_pkg::PhBinFirst, nls_pkg::PhBinDigs: begin
            if (cls.is_bin) begin
               count_mid = count_take;
               phase_mid = nls_pkg::PhBinDigs;
            end else begin
               step_out.done          = 1'b1;
               step_out.rsp.num_base  = nls_pkg::BaseBin;
               step_out.rsp.malformed = (phase_ff == nls_pkg::PhBinFirst) ||
                                        !cls.compatible;
            end
         end
         default: begin
            phase_mid = nls_pkg::PhIdle;
         end
      endcase

      // The ending byte closes the token and clears the count.
      if (step_out.done) begin
         phase_mid = nls_pkg::PhIdle;
         count_mid = 8'd0;
      end

      phase_in = phase_mid;
      count_in = count_mid;

      // A start byte that is a digit or a dot on an idle scanner opens the next token.
      if (phase_mid == nls_pkg::PhIdle && word.start_req && (cls.is_digit || cls.is_dot)) begin
         count_in = 8'd1;
         if (cls.is_zero) begin
            phase_in = nls_pkg::PhZero;
         end else if (cls.is_dot) begin
            phase_in = nls_pkg::PhLeadDot;
         end else begin
            phase_in = nls_pkg::PhDecInt;
         end
      end
   end

   // State advances only when the held byte moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nls_pkg::PhIdle;
         count_ff <= 8'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/numeric_literal_scanner.sv @@
// Top level of the numeric literal scanner: input register, scan core and result register.
//
// Usage: source bytes enter on the req_ channel, one word per byte, with
// start_req set on the byte that begins a numeric token. The rsp_ channel
// gives one word per finished literal: base, float flag, malformed flag and
// the count of bytes taken into the token (saturating at MAX_LEN or 255).
// A result is sent when the first byte that does not belong to the token
// arrives; that byte may start the next token itself.
// Path: a byte accepted into the input register is decoded there, and its
// result word is registered in the result register that drives rsp_valid.
// Throughput: one byte per cycle while no result is held back (see Stall);
// the class decode and phase update sit between the input and result registers.
// Reset: synchronous; clears both valid flags and returns the scanner to
// idle with a zero count.
// Stall: while rsp_stall holds a waiting result, the byte in the input
// register waits and req_stall rises; as soon as the result register is
// empty or draining, one byte moves per cycle again.
`default_nettype none

module numeric_literal_scanner #(
   parameter int unsigned MAX_LEN = 255
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire nls_pkg::req_word_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output nls_pkg::rsp_word_type      rsp_data
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   nls_pkg::req_word_type  in_word_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   nls_pkg::rsp_word_type  out_word_ff;

   logic                   req_accept;
   logic                   out_free;
   logic                   advance;
   nls_pkg::step_out_type  step_out;

   // The held byte moves on when the result register can take a word.
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // Result register holds until the receiver takes the word.
   always_comb begin
      if (advance) begin
         out_valid_in = step_out.done;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   nls_scan_core #(
      .MAX_LEN (MAX_LEN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .word     (in_word_ff),
      .step_out (step_out)
   );

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_word_ff <= req_data;
      end
      if (advance && step_out.done) begin
         out_word_ff <= step_out.rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

`ifndef ASSERT_OFF
   // Only decimal literals carry the float flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.num_base != nls_pkg::BaseDec |-> !rsp_data.is_float)
      else $error("float flag set on a hex or binary literal");

   // The base field never carries the unused code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.num_base == nls_pkg::BaseDec ||
                    rsp_data.num_base == nls_pkg::BaseHex ||
                    rsp_data.num_base == nls_pkg::BaseBin)
      else $error("invalid numeric base in result word");

   // Every token has taken at least its start byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.token_length != 8'd0)
      else $error("result word with zero token length");

   // Input stalls only while a finished result is held back.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire
